>>> sv/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

  localparam int CpW   = 22;
  localparam int ValW  = 21;

  localparam logic [CpW-1:0] CP_ERROR = 22'h3FFFFF;

  // One queue word: the results caused by one input byte (one or two).
  typedef struct packed {
    logic           two;
    logic [CpW-1:0] cp0;
    logic [CpW-1:0] cp1;
  } entry_t;

  // Smallest value that is not overlong, by sequence length minus one.
  function automatic logic [ValW-1:0] min_value(input logic [1:0] len);
    logic [ValW-1:0] m;
    case (len)
      2'd1:    m = 21'h000080;
      2'd2:    m = 21'h000800;
      2'd3:    m = 21'h010000;
      default: m = 21'h000000;
    endcase
    return m;
  endfunction

endpackage

>>> sv/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream into code points, modified null accepted.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue is not full. Each byte gives zero,
// one or two results; the result port moves one word per cycle while
// out_ready is high, so a byte with two results occupies the output for both
// words, absorbed by a two-word queue between the classifier and the result register.
// code_point is -1 for a malformed sequence; out_run_last marks the final
// result caused by a byte. in_last ends the stream and resets the sequence state.
module utf8_stream_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [21:0] out_code_point,
  output logic               out_run_last
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  usd_pkg::entry_t push_word;
  usd_pkg::entry_t head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  usd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .push      (push),
    .push_word (push_word)
  );

  usd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  usd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_run_last   (out_run_last)
  );

endmodule

>>> sv/usd_front.sv
// ----------------------------------------------------------------------------
// usd_front
// Byte classifier and sequence tracker; builds at most one queue word per byte.
// ----------------------------------------------------------------------------
module usd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                push,
  output usd_pkg::entry_t     push_word
);

  logic [1:0]  rem_r, rem_nxt;
  logic [20:0] part_r, part_nxt;
  logic [1:0]  len_r, len_nxt;
  logic        drop_r, drop_nxt;

  logic        cont;
  logic [20:0] shifted;
  logic [3:0]  c_v;
  logic [21:0] c_d [4];
  logic [1:0]  cnt;
  logic [21:0] cp0, cp1;
  logic        bad;

  assign cont    = (in_byte[7:6] == 2'b10);
  assign shifted = {part_r[14:0], in_byte[5:0]};
  assign bad     = (shifted < usd_pkg::min_value(len_r)) &&
                   !(len_r == 2'd1 && shifted == 21'd0);

  always_comb begin
    rem_nxt  = rem_r;
    part_nxt = part_r;
    len_nxt  = len_r;
    drop_nxt = drop_r;
    c_v      = '0;
    for (int i = 0; i < 4; i++) c_d[i] = usd_pkg::CP_ERROR;

    if (cont) begin
      if (rem_r != 2'd0) begin
        part_nxt = shifted;
        rem_nxt  = rem_r - 2'd1;
        if (rem_r == 2'd1) begin
          c_v[0] = 1'b1;
          c_d[0] = bad ? usd_pkg::CP_ERROR : {1'b0, shifted};
        end
      end else if (!drop_r) begin
        drop_nxt = 1'b1;
        c_v[0]   = 1'b1;
      end
    end else begin
      if (rem_r != 2'd0) begin
        rem_nxt = 2'd0;
        c_v[1]  = 1'b1;
      end
      drop_nxt = 1'b1;
      unique case (1'b1)
        !in_byte[7]: begin
          c_v[2] = 1'b1;
          c_d[2] = {14'd0, in_byte};
        end
        in_byte[7:5] == 3'b110: begin
          len_nxt = 2'd1; rem_nxt = 2'd1; part_nxt = {16'd0, in_byte[4:0]};
        end
        in_byte[7:4] == 4'b1110: begin
          len_nxt = 2'd2; rem_nxt = 2'd2; part_nxt = {17'd0, in_byte[3:0]};
        end
        in_byte[7:3] == 5'b11110: begin
          len_nxt = 2'd3; rem_nxt = 2'd3; part_nxt = {18'd0, in_byte[2:0]};
        end
        default: c_v[2] = 1'b1;
      endcase
    end

    if (in_last) begin
      c_v[3]   = (rem_nxt != 2'd0);
      rem_nxt  = 2'd0;
      part_nxt = '0;
      len_nxt  = 2'd0;
      drop_nxt = 1'b0;
    end
  end

  always_comb begin
    cnt = 2'd0;
    cp0 = usd_pkg::CP_ERROR;
    cp1 = usd_pkg::CP_ERROR;
    for (int i = 0; i < 4; i++) begin
      if (c_v[i]) begin
        if (cnt == 2'd0) cp0 = c_d[i];
        else if (cnt == 2'd1) cp1 = c_d[i];
        if (cnt != 2'd2) cnt = cnt + 2'd1;
      end
    end
  end

  assign push           = accept && (cnt != 2'd0);
  assign push_word.two  = (cnt == 2'd2);
  assign push_word.cp0  = cp0;
  assign push_word.cp1  = cp1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 2'd0;
      part_r <= '0;
      len_r  <= 2'd0;
      drop_r <= 1'b0;
    end else if (accept) begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
      len_r  <= len_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

>>> sv/usd_queue.sv
// ----------------------------------------------------------------------------
// usd_queue
// Two-word queue between the classifier and the result stage.
// ----------------------------------------------------------------------------
module usd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  usd_pkg::entry_t     push_word,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output usd_pkg::entry_t     head
);

  usd_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");
`endif

endmodule

>>> sv/usd_back.sv
// ----------------------------------------------------------------------------
// usd_back
// Result stage: unpacks queue words into single results on the output.
// ----------------------------------------------------------------------------
module usd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  usd_pkg::entry_t     head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [21:0]  out_code_point,
  output logic                out_run_last
);

  logic        valid_r, valid_nxt;
  logic        pend_r, pend_nxt;
  logic [21:0] cp_r, cp_nxt;
  logic [21:0] second_r, second_nxt;
  logic        last_r, last_nxt;
  logic        load;

  assign load = !valid_r || out_ready;
  assign pop  = load && !pend_r && !empty;

  always_comb begin
    valid_nxt  = valid_r;
    pend_nxt   = pend_r;
    cp_nxt     = cp_r;
    second_nxt = second_r;
    last_nxt   = last_r;
    if (load) begin
      if (pend_r) begin
        valid_nxt = 1'b1;
        pend_nxt  = 1'b0;
        cp_nxt    = second_r;
        last_nxt  = 1'b1;
      end else if (!empty) begin
        valid_nxt  = 1'b1;
        pend_nxt   = head.two;
        cp_nxt     = head.cp0;
        second_nxt = head.cp1;
        last_nxt   = !head.two;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_r     <= cp_nxt;
    second_r <= second_nxt;
    last_r   <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_point = cp_r;
  assign out_run_last   = last_r;

`ifndef SYNTH
  a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> valid_r) else $error("second result pending without output");
  a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !last_r) else $error("first of two results marked final");
`endif

endmodule

>>> tb/sv/utf8_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench: a directed byte stream that covers the corner cases
// of the decoder (modified null, overlong forms, interrupted and truncated
// sequences, invalid leads, stray and surplus continuations, end of stream),
// then random streams built mostly from well-formed characters. A behavioral
// decoder predicts every code point; results are checked in order, under
// random gaps on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

  localparam int IdleLimit = 2000;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       drain;  // hold this byte until all results are back
  } byte_word_t;

  typedef struct {
    logic signed [usd_pkg::CpW-1:0] cp;
    logic                           run_last;
  } code_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_byte = 8'h00;
  logic                           in_last = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [usd_pkg::CpW-1:0] out_code_point;
  logic                           out_run_last;

  byte_word_t pending_bytes[$];
  code_word_t expected_cps[$];

  // decoder state as seen by the predictor
  logic [1:0]               conts_left = 2'd0;
  logic [1:0]               char_len = 2'd0;
  logic [usd_pkg::ValW-1:0] cp_acc = '0;
  logic                     in_stream = 1'b0;

  int send_gap = 0;
  int recv_stall = 0;
  int bytes_accepted = 0;
  int bytes_total = 0;
  int idle_cycles = 0;
  int fail_count = 0;

  utf8_stream_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_point(out_code_point),
    .out_run_last  (out_run_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [usd_pkg::CpW-1:0]  cps[$];
    logic [usd_pkg::ValW-1:0] lowest;
    code_word_t               w;
    if (b[7:6] == 2'b10) begin
      if (conts_left != 2'd0) begin
        cp_acc = {cp_acc[usd_pkg::ValW-7:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          case (char_len)
            2'd1:    lowest = 21'h000080;
            2'd2:    lowest = 21'h000800;
            2'd3:    lowest = 21'h010000;
            default: lowest = 21'h000000;
          endcase
          if (cp_acc < lowest && !(char_len == 2'd1 && cp_acc == '0)) begin
            cps.push_back(usd_pkg::CP_ERROR);
          end else begin
            cps.push_back({1'b0, cp_acc});
          end
        end
      end else if (!in_stream) begin
        in_stream = 1'b1;
        cps.push_back(usd_pkg::CP_ERROR);
      end
    end else begin
      if (conts_left != 2'd0) begin
        conts_left = 2'd0;
        cps.push_back(usd_pkg::CP_ERROR);
      end
      in_stream = 1'b1;
      casez (b)
        8'b0???????: cps.push_back({14'd0, b});
        8'b110?????: begin
          char_len = 2'd1; conts_left = 2'd1; cp_acc = {16'd0, b[4:0]};
        end
        8'b1110????: begin
          char_len = 2'd2; conts_left = 2'd2; cp_acc = {17'd0, b[3:0]};
        end
        8'b11110???: begin
          char_len = 2'd3; conts_left = 2'd3; cp_acc = {18'd0, b[2:0]};
        end
        default: cps.push_back(usd_pkg::CP_ERROR);
      endcase
    end
    if (last) begin
      if (conts_left != 2'd0) cps.push_back(usd_pkg::CP_ERROR);
      conts_left = 2'd0;
      char_len = 2'd0;
      cp_acc = '0;
      in_stream = 1'b0;
    end
    foreach (cps[i]) begin
      w.cp = cps[i];
      w.run_last = (i == cps.size() - 1);
      expected_cps.push_back(w);
    end
  endfunction

  // One random character: mostly well formed, some noise and broken ones.
  task automatic queue_char();
    int         kind;
    int         conts;
    logic [7:0] lead;
    byte_word_t w;
    kind = $urandom_range(0, 19);
    conts = 0;
    if (kind < 5) begin
      lead = {1'b0, 7'($urandom)};
    end else if (kind < 9) begin
      lead = {3'b110, 5'($urandom)}; conts = 1;
    end else if (kind < 13) begin
      lead = {4'b1110, 4'($urandom)}; conts = 2;
    end else if (kind < 16) begin
      lead = {5'b11110, 3'($urandom)}; conts = 3;
    end else if (kind == 16) begin
      lead = {5'b11111, 3'($urandom)}; conts = $urandom_range(0, 2);
    end else if (kind == 17) begin
      lead = 8'($urandom);
    end else if (kind == 18) begin
      lead = {2'b11, 6'($urandom)}; conts = $urandom_range(0, 2);
    end else begin
      lead = {2'b10, 6'($urandom)};
    end
    w.b = lead;
    w.last = 1'b0;
    w.drain = ($urandom_range(0, 149) == 0);
    pending_bytes.push_back(w);
    w.drain = 1'b0;
    for (int i = 0; i < conts; i++) begin
      w.b = {2'b10, 6'($urandom)};
      pending_bytes.push_back(w);
    end
    if ($urandom_range(0, 11) == 0) pending_bytes[$].last = 1'b1;
  endtask

  // byte source
  always @(posedge clk) begin : drive_p
    bit calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].drain && (in_valid || expected_cps.size() != 0))) begin
        in_valid <= 1'b1;
        in_byte  <= pending_bytes[0].b;
        in_last  <= pending_bytes[0].last;
        void'(pending_bytes.pop_front());
        if ($urandom_range(0, 39) == 0) calm = !calm;
        send_gap <= draw_wait(calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk) begin : sink_p
    bit calm;
    int n;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else if (out_valid && out_ready) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      n = draw_wait(calm);
      recv_stall <= n;
      out_ready  <= (n == 0);
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      out_ready  <= (recv_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // prediction on each accepted byte, then compare each accepted word
  always @(posedge clk) begin : check_p
    code_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte, in_last);
        bytes_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_cps.size() == 0) begin
          note_failure($sformatf("unexpected code point %0d run_last %0b",
                                 out_code_point, out_run_last));
        end else begin
          want = expected_cps.pop_front();
          if (out_code_point !== want.cp)
            note_failure($sformatf("code_point expected %0d, got %0d",
                                   want.cp, out_code_point));
          if (out_run_last !== want.run_last)
            note_failure($sformatf("run_last expected %0b, got %0b (cp %0d)",
                                   want.run_last, out_run_last, want.cp));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog_p
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("utf8_stream_decoder test failed");
    $finish;
  end

  initial begin : main_p
    logic [8:0] directed[26];  // {last, byte}
    byte_word_t w;
    directed = '{9'h080, 9'h0BF, 9'h000, 9'h0C0, 9'h080, 9'h0C1, 9'h0BF,
                 9'h0E0, 9'h0A0, 9'h080, 9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
                 9'h080, 9'h0F8, 9'h0FF, 9'h0E2, 9'h082, 9'h041, 9'h0F0,
                 9'h190, 9'h080, 9'h07F, 9'h0C2, 9'h1E0};
    foreach (directed[i]) begin
      w.b = directed[i][7:0];
      w.last = directed[i][8];
      w.drain = (i == 22);  // new stream only after the first has drained
      pending_bytes.push_back(w);
    end
    while (pending_bytes.size() < 926) queue_char();
    bytes_total = pending_bytes.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted != bytes_total) @(posedge clk);
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_cps.size() != 0)
      note_failure($sformatf("%0d code points never arrived", expected_cps.size()));
    if (fail_count == 0) begin
      $display("utf8_stream_decoder test passed");
    end else begin
      $display("utf8_stream_decoder test failed");
    end
    $finish;
  end

endmodule

>>> utf8_stream_decoder.f
sv/usd_pkg.sv
sv/usd_front.sv
sv/usd_queue.sv
sv/usd_back.sv
sv/utf8_stream_decoder.sv
tb/sv/utf8_stream_decoder_tb.sv
